// ----- src/sil_pkg.sv -----
// ----------------------------------------------------------------------------
// sil_pkg
// Types and constants shared by the silhouette edge test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

  localparam int COORD_W  = 16;
  localparam int ROW_W    = 64;
  localparam int NUM_ROWS = 3;
  localparam int ADDR_W   = 5;
  localparam int FRAC_W   = 12;
  localparam int SPLIT_W  = 17;
  localparam int CAM_W    = 34;
  localparam int PART_W   = 36;
  localparam int SUM_W    = 39;
  localparam int TOTAL_W  = 74;
  localparam int LATENCY  = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] xform_t;

  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t nx;
    coord_t ny;
    coord_t nz;
  } face_t;

  typedef struct packed {
    logic valid;
    logic pos;
    logic neg;
  } face_sign_t;

endpackage

`default_nettype wire

// ----- src/sil_face.sv -----
// ----------------------------------------------------------------------------
// sil_face
// Five-stage pipeline: camera transform of one face's vertex and normal,
// exact dot product, sign of the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_face (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sil_pkg::face_t      face,
  input  sil_pkg::xform_t     xform,
  output sil_pkg::face_sign_t sign_o
);
  import sil_pkg::*;

  // stage 1: matrix products
  logic                      v1_r;
  logic signed [2*COORD_W-1:0] pp_r [NUM_ROWS][3];
  logic signed [2*COORD_W-1:0] np_r [NUM_ROWS][3];
  coord_t                    mt_r [NUM_ROWS];
  // stage 2: camera-space vectors
  logic                      v2_r;
  logic signed [CAM_W-1:0]   pc_r [NUM_ROWS];
  logic signed [CAM_W-1:0]   nc_r [NUM_ROWS];
  // stage 3: split partial products
  logic                      v3_r;
  logic signed [PART_W-1:0]  hh_r [NUM_ROWS];
  logic signed [PART_W-1:0]  hl_r [NUM_ROWS];
  logic signed [PART_W-1:0]  lh_r [NUM_ROWS];
  logic signed [PART_W-1:0]  ll_r [NUM_ROWS];
  // stage 4: sums per weight
  logic                      v4_r;
  logic signed [SUM_W-1:0]   s_hh_r;
  logic signed [SUM_W-1:0]   s_mid_r;
  logic signed [SUM_W-1:0]   s_ll_r;
  // stage 5: sign
  face_sign_t                sign_r;

  coord_t                    pv [3];
  coord_t                    nv [3];
  logic signed [17:0]        p_hi [NUM_ROWS];
  logic signed [17:0]        p_lo [NUM_ROWS];
  logic signed [17:0]        n_hi [NUM_ROWS];
  logic signed [17:0]        n_lo [NUM_ROWS];
  logic signed [TOTAL_W-1:0] total;

  assign pv[0] = face.px;
  assign pv[1] = face.py;
  assign pv[2] = face.pz;
  assign nv[0] = face.nx;
  assign nv[1] = face.ny;
  assign nv[2] = face.nz;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      mt_r[i] <= coord_t'(xform[i][3*COORD_W +: COORD_W]);
      for (int j = 0; j < 3; j++) begin
        pp_r[i][j] <= coord_t'(xform[i][j*COORD_W +: COORD_W]) * pv[j];
        np_r[i][j] <= coord_t'(xform[i][j*COORD_W +: COORD_W]) * nv[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      pc_r[i] <= (CAM_W'(mt_r[i]) <<< FRAC_W) + CAM_W'(pp_r[i][0])
               + CAM_W'(pp_r[i][1]) + CAM_W'(pp_r[i][2]);
      nc_r[i] <= CAM_W'(np_r[i][0]) + CAM_W'(np_r[i][1]) + CAM_W'(np_r[i][2]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      p_hi[i] = {pc_r[i][CAM_W-1], pc_r[i][CAM_W-1:SPLIT_W]};
      p_lo[i] = {1'b0, pc_r[i][SPLIT_W-1:0]};
      n_hi[i] = {nc_r[i][CAM_W-1], nc_r[i][CAM_W-1:SPLIT_W]};
      n_lo[i] = {1'b0, nc_r[i][SPLIT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      hh_r[i] <= p_hi[i] * n_hi[i];
      hl_r[i] <= p_hi[i] * n_lo[i];
      lh_r[i] <= p_lo[i] * n_hi[i];
      ll_r[i] <= p_lo[i] * n_lo[i];
    end
  end

  always_ff @(posedge clk) begin
    s_hh_r  <= SUM_W'(hh_r[0]) + SUM_W'(hh_r[1]) + SUM_W'(hh_r[2]);
    s_mid_r <= SUM_W'(hl_r[0]) + SUM_W'(hl_r[1]) + SUM_W'(hl_r[2])
             + SUM_W'(lh_r[0]) + SUM_W'(lh_r[1]) + SUM_W'(lh_r[2]);
    s_ll_r  <= SUM_W'(ll_r[0]) + SUM_W'(ll_r[1]) + SUM_W'(ll_r[2]);
  end

  assign total = (TOTAL_W'(s_hh_r) <<< (2*SPLIT_W)) + (TOTAL_W'(s_mid_r) <<< SPLIT_W)
               + TOTAL_W'(s_ll_r);

  // sum p*n: positive means back-facing, negative means front-facing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      sign_r <= '0;
    end else begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      sign_r.valid <= v4_r;
      sign_r.pos   <= ~total[TOTAL_W-1] & (|total);
      sign_r.neg   <= total[TOTAL_W-1];
    end
  end

  assign sign_o = sign_r;

endmodule

`default_nettype wire

// ----- src/silhouette_edge_test_core.sv -----
// ----------------------------------------------------------------------------
// silhouette_edge_test_core
// Silhouette test of one mesh edge: both adjacent faces are moved into
// camera space and the edge is flagged when their facing signs are
// strictly opposite.
//
//   channel  | handshake                          | payload
//   ---------+------------------------------------+---------------------------
//   input    | start && !busy                     | in_face_{a,b}_{p,n}{x,y,z}
//   result   | out_valid (one cycle, no stall)    | out_is_silhouette
//   config   | psel && penable && pwrite && pready| paddr[4:3], pwdata
//
// One transaction per cycle; busy stays low.
// Each edge passes five stages per face (products, camera vectors,
// split partial products, weighted sums, sign) and then the output register.
// rst_n is synchronous; it clears the pipeline valids and loads the
// identity transform.
// ----------------------------------------------------------------------------
`default_nettype none

module silhouette_edge_test_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  sil_pkg::coord_t            in_face_a_px,
  input  sil_pkg::coord_t            in_face_a_py,
  input  sil_pkg::coord_t            in_face_a_pz,
  input  sil_pkg::coord_t            in_face_a_nx,
  input  sil_pkg::coord_t            in_face_a_ny,
  input  sil_pkg::coord_t            in_face_a_nz,
  input  sil_pkg::coord_t            in_face_b_px,
  input  sil_pkg::coord_t            in_face_b_py,
  input  sil_pkg::coord_t            in_face_b_pz,
  input  sil_pkg::coord_t            in_face_b_nx,
  input  sil_pkg::coord_t            in_face_b_ny,
  input  sil_pkg::coord_t            in_face_b_nz,
  output logic                       out_valid,
  output logic                       out_is_silhouette,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sil_pkg::ADDR_W-1:0] paddr,
  input  logic [sil_pkg::ROW_W-1:0]  pwdata,
  output logic [sil_pkg::ROW_W-1:0]  prdata,
  output logic                       pready
);
  import sil_pkg::*;

  xform_t     xform_r;
  xform_t     xform_nxt;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  logic       in_fire;
  face_t      face_a;
  face_t      face_b;
  face_sign_t sign_a;
  face_sign_t sign_b;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_sil_r;
  logic       out_sil_nxt;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign in_fire = start & ~busy;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_comb begin
    xform_nxt = xform_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ROW0: xform_nxt[0] = pwdata;
        REG_ROW1: xform_nxt[1] = pwdata;
        REG_ROW2: xform_nxt[2] = pwdata;
        default:  xform_nxt    = xform_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW0: prdata = xform_r[0];
      REG_ROW1: prdata = xform_r[1];
      REG_ROW2: prdata = xform_r[2];
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xform_r[0] <= ROW_W'(64'h0000_0000_0000_1000);
      xform_r[1] <= ROW_W'(64'h0000_0000_1000_0000);
      xform_r[2] <= ROW_W'(64'h0000_1000_0000_0000);
    end else begin
      xform_r <= xform_nxt;
    end
  end

  assign face_a = '{px: in_face_a_px, py: in_face_a_py, pz: in_face_a_pz,
                    nx: in_face_a_nx, ny: in_face_a_ny, nz: in_face_a_nz};
  assign face_b = '{px: in_face_b_px, py: in_face_b_py, pz: in_face_b_pz,
                    nx: in_face_b_nx, ny: in_face_b_ny, nz: in_face_b_nz};

  sil_face u_face_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .face     (face_a),
    .xform    (xform_r),
    .sign_o   (sign_a)
  );

  sil_face u_face_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .face     (face_b),
    .xform    (xform_r),
    .sign_o   (sign_b)
  );

  assign out_valid_nxt = sign_a.valid & sign_b.valid;
  assign out_sil_nxt   = out_valid_nxt & ((sign_a.pos & sign_b.neg) | (sign_a.neg & sign_b.pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_sil_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_sil_r   <= out_sil_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_silhouette = out_sil_r;

`ifndef SYNTH
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("result without a matching input transaction");

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##6 out_valid)
    else $error("input transaction produced no result");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_is_silhouette)
    else $error("silhouette flag outside a result");

  a_cfg_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && reg_idx == REG_ROW0) |=> xform_r[0] == $past(pwdata))
    else $error("row 0 write lost");
`endif

endmodule

`default_nettype wire

// ----- dv/silhouette_edge_test_core_test.sv -----
// ----------------------------------------------------------------------------
// silhouette_edge_test_core_test
// Self-checking bench for the silhouette edge test core. A queue-fed driver
// sends mesh edges on the start/busy channel, and an exact wide-integer
// predictor computes the facing signs of both faces under the current
// camera rows. A monitor checks every out_valid transaction in order. The
// camera rows are rewritten over the APB port between phases, read back,
// and taken through zero, full-scale and random settings.
// ----------------------------------------------------------------------------
`default_nettype none

module silhouette_edge_test_core_test;
  import sil_pkg::*;

  typedef struct packed {
    face_t fa;
    face_t fb;
  } mesh_edge_t;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic                 start   = 1'b0;
  face_t                in_a    = '0;
  face_t                in_b    = '0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_W-1:0]    paddr   = '0;
  logic [ROW_W-1:0]     pwdata  = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_is_silhouette;
  logic [ROW_W-1:0]     prdata;
  logic                 pready;

  mesh_edge_t mesh_edge_q[$];
  bit         silhouette_q[$];
  mesh_edge_t on_bus;
  xform_t     cam_rows;
  int         idle_pct   = 0;
  int         mismatches = 0;

  silhouette_edge_test_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_face_a_px      (in_a.px),
    .in_face_a_py      (in_a.py),
    .in_face_a_pz      (in_a.pz),
    .in_face_a_nx      (in_a.nx),
    .in_face_a_ny      (in_a.ny),
    .in_face_a_nz      (in_a.nz),
    .in_face_b_px      (in_b.px),
    .in_face_b_py      (in_b.py),
    .in_face_b_pz      (in_b.pz),
    .in_face_b_nx      (in_b.nx),
    .in_face_b_ny      (in_b.ny),
    .in_face_b_nz      (in_b.nz),
    .out_valid         (out_valid),
    .out_is_silhouette (out_is_silhouette),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sign of dot(-p_cam, n_cam), exact
  function automatic int facing_sign(face_t f, xform_t m);
    logic signed [127:0] pv [3];
    logic signed [127:0] nv [3];
    logic signed [127:0] pc, nc, total;
    logic signed [15:0]  e;
    pv[0] = $signed(f.px);
    pv[1] = $signed(f.py);
    pv[2] = $signed(f.pz);
    nv[0] = $signed(f.nx);
    nv[1] = $signed(f.ny);
    nv[2] = $signed(f.nz);
    total = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      e  = m[i][48 +: 16];
      pc = e;
      pc = pc <<< FRAC_W;
      nc = '0;
      for (int j = 0; j < 3; j++) begin
        e  = m[i][16*j +: 16];
        pc = pc + e * pv[j];
        nc = nc + e * nv[j];
      end
      total = total + pc * nc;
    end
    if (total > 0) return -1;
    if (total < 0) return 1;
    return 0;
  endfunction

  function automatic bit silhouette_of(mesh_edge_t m);
    int sa, sb;
    sa = facing_sign(m.fa, cam_rows);
    sb = facing_sign(m.fb, cam_rows);
    return (sa * sb) < 0;
  endfunction

  function automatic face_t mk_face(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                    logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    face_t f;
    f.px = px; f.py = py; f.pz = pz;
    f.nx = nx; f.ny = ny; f.nz = nz;
    return f;
  endfunction

  function automatic coord_t rand_coord(bit narrow);
    return narrow ? coord_t'($urandom_range(8) - 4) : coord_t'($urandom);
  endfunction

  function automatic face_t rand_face(bit narrow);
    return mk_face(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
                   rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
  endfunction

  function automatic mesh_edge_t make_edge();
    mesh_edge_t m;
    int unsigned k;
    k    = $urandom_range(99);
    m.fa = rand_face(k < 30);
    m.fb = rand_face(k < 30 || k >= 90);
    if (k >= 60 && k < 80) begin
      // shared vertex, flipped normal: opposite signs unless degenerate
      m.fb = mk_face(m.fa.px, m.fa.py, m.fa.pz, -m.fa.nx, -m.fa.ny, -m.fa.nz);
    end else if (k >= 80 && k < 90) begin
      if ($urandom_range(1)) m.fa = mk_face(m.fa.px, m.fa.py, m.fa.pz, 0, 0, 0);
      else m.fb = mk_face(m.fb.px, m.fb.py, m.fb.pz, 0, 0, 0);
    end else if (k >= 90 && k < 95) begin
      m.fb = mk_face(m.fa.px, m.fa.py, m.fa.pz, m.fa.nx, m.fa.ny, m.fa.nz);
    end
    return m;
  endfunction

  function automatic void enqueue(mesh_edge_t m);
    mesh_edge_q.insert(mesh_edge_q.size(), m);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) silhouette_q.insert(silhouette_q.size(), silhouette_of(on_bus));
      if (!start || !busy) begin
        if (mesh_edge_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = mesh_edge_q.pop_front();
          start <= 1'b1;
          in_a  <= on_bus.fa;
          in_b  <= on_bus.fb;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (silhouette_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %b", $time,
                 out_is_silhouette);
        mismatches++;
      end else begin
        bit want;
        want = silhouette_q.pop_front();
        if (out_is_silhouette !== want) begin
          $display("%0t: is_silhouette mismatch, expected %b actual %b", $time,
                   want, out_is_silhouette);
          mismatches++;
        end
      end
    end
  end

  task automatic apb_access(reg_idx_t idx, bit wr, logic [ROW_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (wr) begin
      if (idx != REG_NONE) cam_rows[idx] = value;
    end else if (prdata !== cam_rows[idx]) begin
      $display("%0t: row %0d readback mismatch, expected %h actual %h", $time,
               idx, cam_rows[idx], prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_rows(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                           logic [ROW_W-1:0] r2);
    apb_access(REG_ROW0, 1'b1, r0);
    apb_access(REG_ROW1, 1'b1, r1);
    apb_access(REG_ROW2, 1'b1, r2);
    apb_access(REG_ROW0, 1'b0, '0);
    apb_access(REG_ROW1, 1'b0, '0);
    apb_access(REG_ROW2, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (mesh_edge_q.size() != 0 || start || silhouette_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int n, int pct);
    idle_pct = pct;
    repeat (n) enqueue(make_edge());
    wait_drained();
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ROW_W-1:0] narrow_row(int diag);
    logic [ROW_W-1:0] r;
    r = '0;
    r[16*diag +: 16] = 16'h1000;
    r[48 +: 16]      = coord_t'($urandom_range(8) - 4) <<< 10;
    return r;
  endfunction

  initial begin
    face_t zero_f, fwd_f, back_f;
    cam_rows[REG_ROW0] = 64'h0000_0000_0000_1000;
    cam_rows[REG_ROW1] = 64'h0000_0000_1000_0000;
    cam_rows[REG_ROW2] = 64'h0000_1000_0000_0000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    zero_f = mk_face(0, 0, 0, 0, 0, 0);
    fwd_f  = mk_face(0, 0, 16'hF000, 0, 0, 16'h1000);
    back_f = mk_face(0, 0, 16'hF000, 0, 0, 16'hF000);
    idle_pct = 33;
    enqueue('{zero_f, zero_f});
    enqueue('{fwd_f, back_f});
    enqueue('{back_f, fwd_f});
    enqueue('{fwd_f, fwd_f});
    enqueue('{mk_face(0, 0, 16'hF000, 0, 0, 0), back_f});
    enqueue('{mk_face(0, 0, 0, 16'h1000, 0, 0),
              mk_face(0, 0, 0, 16'hF000, 0, 0)});
    enqueue('{mk_face(16'h1000, 0, 0, 0, 16'h1000, 0), back_f});
    enqueue('{mk_face(16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h7FFF, 16'h7FFF, 16'h7FFF),
              mk_face(16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000)});
    enqueue('{mk_face(16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h8000, 16'h8000, 16'h8000),
              mk_face(16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h7FFF, 16'h7FFF, 16'h7FFF)});
    enqueue('{mk_face(16'h8000, 16'h7FFF, 16'h8000,
                      16'h7FFF, 16'h8000, 16'h7FFF),
              mk_face(16'h7FFF, 16'h8000, 16'h7FFF,
                      16'h7FFF, 16'h8000, 16'h7FFF)});
    enqueue('{mk_face(16'hFFFF, 16'h0001, 16'hFFFF,
                      16'h0001, 16'hFFFF, 16'h0001),
              mk_face(16'h0001, 16'hFFFF, 16'h0001,
                      16'h0001, 16'hFFFF, 16'h0001)});
    wait_drained();

    // write to the unused index must leave the transform alone
    apb_access(REG_NONE, 1'b1, {ROW_W{1'b1}});
    enqueue('{fwd_f, back_f});
    enqueue('{back_f, back_f});
    wait_drained();

    load_rows(rand_row(), rand_row(), rand_row());
    run_random(200, 33);
    load_rows({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    run_random(200, 33);
    load_rows({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    run_random(200, 78);
    load_rows(narrow_row(0), narrow_row(1), narrow_row(2));
    run_random(200, 78);
    load_rows('0, '0, '0);
    run_random(100, 0);
    load_rows({4{16'hFFFF}}, rand_row(), {4{16'h8000}});
    run_random(100, 0);
    load_rows(rand_row(), rand_row(), rand_row());
    run_random(200, 0);

    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
